@@ src/lrha_pkg.sv @@
package lrha_pkg;

  localparam logic [4:0] RING_SIZE   = 5'd24;
  localparam logic [9:0] ELAPSED_MAX = 10'd1023;

  // Exact floor(h / 360) for any 16-bit h: (h * 46604) >> 24
  localparam logic [31:0] DIV360_MUL = 32'd46604;
  localparam int          DIV360_SH  = 24;
  // Exact floor(x / 15) for x below 375: (x * 2185) >> 15
  localparam logic [20:0] DIV15_MUL  = 21'd2185;
  localparam int          DIV15_SH   = 15;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_HEADING = 2'd1,
    REQ_SPEED   = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  localparam logic CFG_MS_PER_TICK = 1'b0;
  localparam logic CFG_GLIDE_MS    = 1'b1;

  // One unit of work for the pixel sequencer
  typedef struct packed {
    logic       frame;   // 0: glide fade, 1: travelling frame
    logic [4:0] ctr;     // new glide pixel, or shown front for a frame
    logic [2:0] tf;      // travel phase 0..5
  } cmd_t;

  typedef struct packed {
    logic [4:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       show_last;
  } pix_t;

  function automatic logic [4:0] ring_add(input logic [4:0] a, input logic [4:0] off);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, off};
    if (s >= {1'b0, RING_SIZE}) begin
      s = s - {1'b0, RING_SIZE};
    end
    return s[4:0];
  endfunction

  // Glide fade order: centre, then +1/-1, +2/-2, +3/-3 (negatives as 24-k)
  function automatic logic [4:0] glide_off(input logic [2:0] step);
    logic [4:0] r;
    case (step)
      3'd0:    r = 5'd0;
      3'd1:    r = 5'd1;
      3'd2:    r = 5'd23;
      3'd3:    r = 5'd2;
      3'd4:    r = 5'd22;
      3'd5:    r = 5'd3;
      3'd6:    r = 5'd21;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] glide_lvl(input logic [2:0] step);
    logic [7:0] r;
    case (step)
      3'd0:         r = 8'd255;
      3'd1, 3'd2:   r = 8'd205;
      3'd3, 3'd4:   r = 8'd155;
      3'd5, 3'd6:   r = 8'd105;
      default:      r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] frame_lvl(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = 8'd5;
      3'd1:    r = 8'd30;
      3'd2:    r = 8'd55;
      3'd3:    r = 8'd80;
      3'd4:    r = 8'd105;
      3'd5:    r = 8'd255;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

@@ src/led_ring_heading_animator.sv @@
// Requests are taken one per cycle while in_full is low, via a two-stage heading divide
// (quotient, then remainder) to the state update; a tick's command then waits in a two-entry
// command queue for the sequencer, which loads it and then writes one pixel per cycle unless
// the output is held: a glide is seven writes and a frame seventeen, after a load state.
// Synchronous active-low reset restores all animation state and valid flags, no data regs.
module led_ring_heading_animator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_heading_deg,
  input  logic [7:0]  in_speed_value,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [4:0]  out_pixel_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_show_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;
  lrha_pkg::cmd_t q_wdata;
  lrha_pkg::cmd_t q_head;
  lrha_pkg::pix_t pix;

  lrha_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_req_type    (in_req_type),
    .in_heading_deg (in_heading_deg),
    .in_speed_value (in_speed_value),
    .in_full        (in_full),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_full         (q_full),
    .cmd_push       (q_push),
    .cmd_data       (q_wdata)
  );

  lrha_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  lrha_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_pix   (pix)
  );

  assign out_pixel_index = pix.pixel_index;
  assign out_red         = pix.red;
  assign out_green       = pix.green;
  assign out_blue        = pix.blue;
  assign out_show_last   = pix.show_last;

endmodule

@@ src/lrha_front.sv @@
module lrha_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [1:0]        in_req_type,
  input  logic [15:0]       in_heading_deg,
  input  logic [7:0]        in_speed_value,
  output logic              in_full,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              q_full,
  output logic              cmd_push,
  output lrha_pkg::cmd_t    cmd_data
);

  logic adv;

  // stage 1: quotient of heading by 360
  logic        s1_valid_r, s1_valid_nxt;
  logic [1:0]  s1_req_r;
  logic [15:0] s1_h_r;
  logic [7:0]  s1_q_r;
  logic [7:0]  s1_spd_r;
  logic [31:0] q_prod;

  // stage 2: heading remainder plus rounding bias
  logic        s2_valid_r, s2_valid_nxt;
  logic [1:0]  s2_req_r;
  logic [8:0]  s2_x_r;
  logic [7:0]  s2_spd_r;
  logic [16:0] qm;
  logic [15:0] rem;

  // animation state
  logic [7:0] ms_r, ms_nxt;
  logic [7:0] gi_r, gi_nxt;
  logic       mode_r, mode_nxt;
  logic [7:0] seen_r, seen_nxt;
  logic [7:0] fint_r, fint_nxt;
  logic [4:0] tgt_r, tgt_nxt;
  logic [4:0] glide_r, glide_nxt;
  logic [4:0] shown_r, shown_nxt;
  logic [2:0] tf_r, tf_nxt;
  logic [9:0] elap_r, elap_nxt;

  logic [20:0] f_prod;
  logic [4:0]  f_pix;
  logic [10:0] e_sum;
  logic [9:0]  e_new;
  logic signed [6:0] delta;
  logic [4:0]  gmod;
  logic [4:0]  g_step;
  logic [8:0]  spd_inc;
  logic [8:0]  dec;

  assign adv     = !q_full;
  assign in_full = !adv;

  assign q_prod = {16'd0, in_heading_deg} * lrha_pkg::DIV360_MUL;

  assign qm  = {9'd0, s1_q_r} * 17'd360;
  assign rem = s1_h_r - qm[15:0];

  assign f_prod = {12'd0, s2_x_r} * lrha_pkg::DIV15_MUL;

  always_comb begin
    f_pix = f_prod[lrha_pkg::DIV15_SH +: 5];
    if (f_pix >= lrha_pkg::RING_SIZE) begin
      f_pix = 5'd0;
    end
  end

  always_comb begin
    e_sum = {1'b0, elap_r} + {3'd0, ms_r};
    e_new = (e_sum > {1'b0, lrha_pkg::ELAPSED_MAX}) ? lrha_pkg::ELAPSED_MAX : e_sum[9:0];
    // shortest way round; raw glide position keeps the reset value of 25 honest
    delta = $signed({2'b00, tgt_r}) - $signed({2'b00, glide_r});
    if (delta > 7'sd12) begin
      delta = delta - 7'sd24;
    end else if (delta <= -7'sd12) begin
      delta = delta + 7'sd24;
    end
    gmod = (glide_r >= lrha_pkg::RING_SIZE) ? glide_r - lrha_pkg::RING_SIZE : glide_r;
    if (delta > 7'sd0) begin
      g_step = lrha_pkg::ring_add(gmod, 5'd1);
    end else begin
      g_step = lrha_pkg::ring_add(gmod, 5'd23);
    end
    spd_inc = {1'b0, s2_spd_r} + 9'd1;
    dec     = {1'b0, s2_spd_r} + {1'b0, spd_inc[8:1]};
  end

  always_comb begin
    ms_nxt    = ms_r;
    gi_nxt    = gi_r;
    mode_nxt  = mode_r;
    seen_nxt  = seen_r;
    fint_nxt  = fint_r;
    tgt_nxt   = tgt_r;
    glide_nxt = glide_r;
    shown_nxt = shown_r;
    tf_nxt    = tf_r;
    elap_nxt  = elap_r;
    cmd_push  = 1'b0;
    cmd_data  = '0;

    if (cfg_we) begin
      case (cfg_index)
        lrha_pkg::CFG_MS_PER_TICK: ms_nxt = cfg_data;
        lrha_pkg::CFG_GLIDE_MS:    gi_nxt = cfg_data;
        default: ;
      endcase
    end

    if (adv && s2_valid_r) begin
      case (lrha_pkg::req_t'(s2_req_r))
        lrha_pkg::REQ_TICK: begin
          elap_nxt = e_new;
          if (mode_r) begin
            if (tgt_r != glide_r) begin
              if ({2'd0, gi_r} <= e_new) begin
                glide_nxt     = g_step;
                elap_nxt      = '0;
                cmd_push      = 1'b1;
                cmd_data.frame = 1'b0;
                cmd_data.ctr  = g_step;
                cmd_data.tf   = tf_r;
                if (g_step == tgt_r) begin
                  shown_nxt = tgt_r;
                  tf_nxt    = '0;
                end
              end
            end else if ({2'd0, fint_r} <= e_new) begin
              elap_nxt       = '0;
              cmd_push       = 1'b1;
              cmd_data.frame = 1'b1;
              cmd_data.ctr   = shown_r;
              cmd_data.tf    = tf_r;
              tf_nxt         = (tf_r >= 3'd5) ? 3'd0 : tf_r + 3'd1;
            end
          end
        end
        lrha_pkg::REQ_HEADING: begin
          if (f_pix != glide_r) begin
            tgt_nxt = f_pix;
          end
        end
        lrha_pkg::REQ_SPEED: begin
          if (s2_spd_r != seen_r) begin
            seen_nxt = s2_spd_r;
            if (s2_spd_r != 8'd0) begin
              fint_nxt = (dec >= 9'd190) ? 8'd15 : 8'(9'd205 - dec);
              mode_nxt = 1'b1;
            end else begin
              mode_nxt = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign s1_valid_nxt = adv ? in_push : s1_valid_r;
  assign s2_valid_nxt = adv ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      ms_r       <= 8'd2;
      gi_r       <= 8'd25;
      mode_r     <= 1'b0;
      seen_r     <= 8'd1;
      fint_r     <= 8'd203;
      tgt_r      <= 5'd0;
      glide_r    <= 5'd25;
      shown_r    <= 5'd0;
      tf_r       <= 3'd0;
      elap_r     <= 10'd0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      ms_r       <= ms_nxt;
      gi_r       <= gi_nxt;
      mode_r     <= mode_nxt;
      seen_r     <= seen_nxt;
      fint_r     <= fint_nxt;
      tgt_r      <= tgt_nxt;
      glide_r    <= glide_nxt;
      shown_r    <= shown_nxt;
      tf_r       <= tf_nxt;
      elap_r     <= elap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req_r <= in_req_type;
      s1_h_r   <= in_heading_deg;
      s1_q_r   <= q_prod[lrha_pkg::DIV360_SH +: 8];
      s1_spd_r <= in_speed_value;
      s2_req_r <= s1_req_r;
      s2_x_r   <= rem[8:0] + 9'd7;
      s2_spd_r <= s1_spd_r;
    end
  end

endmodule

@@ src/lrha_cmdq.sv @@
module lrha_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lrha_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output lrha_pkg::cmd_t head
);

  logic           v0_r, v0_nxt;
  logic           v1_r, v1_nxt;
  lrha_pkg::cmd_t e0_r, e0_nxt;
  lrha_pkg::cmd_t e1_r, e1_nxt;
  logic           do_pop;

  assign full   = v1_r;
  assign empty  = !v0_r;
  assign head   = e0_r;
  assign do_pop = pop && v0_r;

  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    e0_nxt = e0_r;
    e1_nxt = e1_r;
    if (do_pop) begin
      // advance the second slot into the head, or refill the head from a push
      if (v1_r) begin
        e0_nxt = e1_r;
        e1_nxt = push_data;
        v1_nxt = push;
      end else begin
        e0_nxt = push_data;
        v0_nxt = push;
      end
    end else if (push) begin
      if (!v0_r) begin
        e0_nxt = push_data;
        v0_nxt = 1'b1;
      end else begin
        e1_nxt = push_data;
        v1_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

endmodule

@@ src/lrha_back.sv @@
module lrha_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  lrha_pkg::cmd_t q_head,
  output logic           q_pop,
  input  logic           out_pop,
  output logic           out_empty,
  output lrha_pkg::pix_t out_pix
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_GLIDE = 3'b010,
    ST_FRAME = 3'b100
  } seq_state_t;

  seq_state_t     state_r, state_nxt;
  logic [4:0]     ctr_r, ctr_nxt;
  logic [2:0]     tf_r, tf_nxt;
  logic [2:0]     step_r, step_nxt;   // glide write, or frame group
  logic [1:0]     sub_r, sub_nxt;     // write within a frame group
  logic           ovalid_r, ovalid_nxt;
  lrha_pkg::pix_t opix_r, opix_nxt;

  logic           emit;
  logic [3:0]     ti_sum;
  logic [2:0]     ti;
  logic [1:0]     last_sub;
  logic [4:0]     off;
  logic [7:0]     lvl;

  assign out_empty = !ovalid_r;
  assign out_pix   = opix_r;
  assign emit      = (state_r != ST_IDLE) && (!ovalid_r || out_pop);
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    ti_sum = {1'b0, tf_r} + {1'b0, step_r};
    ti     = (ti_sum >= 4'd6) ? 3'(ti_sum - 4'd6) : ti_sum[2:0];
    case (ti)
      3'd3:       last_sub = 2'd2;
      3'd4, 3'd5: last_sub = 2'd3;
      default:    last_sub = 2'd1;
    endcase
    case (sub_r)
      2'd0:    off = 5'(4'd9 - {1'b0, ti});
      2'd1:    off = 5'd15 + {2'd0, ti};
      2'd2:    off = 5'd9 + {2'd0, ti};
      default: off = 5'(4'd15 - {1'b0, ti});
    endcase
    lvl = lrha_pkg::frame_lvl(step_r);
  end

  always_comb begin
    state_nxt  = state_r;
    ctr_nxt    = ctr_r;
    tf_nxt     = tf_r;
    step_nxt   = step_r;
    sub_nxt    = sub_r;
    opix_nxt   = opix_r;
    ovalid_nxt = (out_pop && ovalid_r) ? 1'b0 : ovalid_r;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          ctr_nxt   = q_head.ctr;
          tf_nxt    = q_head.tf;
          step_nxt  = '0;
          sub_nxt   = '0;
          state_nxt = q_head.frame ? ST_FRAME : ST_GLIDE;
        end
      end
      ST_GLIDE: begin
        if (emit) begin
          ovalid_nxt           = 1'b1;
          opix_nxt.pixel_index = lrha_pkg::ring_add(ctr_r, lrha_pkg::glide_off(step_r));
          opix_nxt.red         = lrha_pkg::glide_lvl(step_r);
          opix_nxt.green       = lrha_pkg::glide_lvl(step_r);
          opix_nxt.blue        = lrha_pkg::glide_lvl(step_r);
          opix_nxt.show_last   = (step_r == 3'd6);
          if (step_r == 3'd6) begin
            state_nxt = ST_IDLE;
          end else begin
            step_nxt = step_r + 3'd1;
          end
        end
      end
      ST_FRAME: begin
        if (emit) begin
          ovalid_nxt           = 1'b1;
          opix_nxt.pixel_index = lrha_pkg::ring_add(ctr_r, off);
          opix_nxt.blue        = (sub_r == 2'd0) ? lvl : 8'd0;
          opix_nxt.green       = (sub_r == 2'd1) ? lvl : 8'd0;
          opix_nxt.red         = (sub_r >= 2'd2) ? lvl : 8'd0;
          opix_nxt.show_last   = (step_r == 3'd5) && (sub_r == last_sub);
          if (sub_r == last_sub) begin
            sub_nxt = '0;
            if (step_r == 3'd5) begin
              state_nxt = ST_IDLE;
            end else begin
              step_nxt = step_r + 3'd1;
            end
          end else begin
            sub_nxt = sub_r + 2'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctr_r  <= ctr_nxt;
    tf_r   <= tf_nxt;
    step_r <= step_nxt;
    sub_r  <= sub_nxt;
    opix_r <= opix_nxt;
  end

endmodule
